/* rtl/swbp_pkg.sv */
// Shared types, codes and defaults of the stack with block promotion.
package swbp_pkg;

	// Default configuration of the stack.
	localparam int STACK_DEPTH_DEF = 64;
	localparam int WORD_BITS_DEF   = 32;

	// Field widths of the request and the result.
	localparam int OPCODE_W = 2;
	localparam int VALUE_W  = 32;
	localparam int START_W  = 6;
	localparam int RUN_W    = 7;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 7;

	// Request opcodes.
	localparam logic [OPCODE_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_POP     = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_PROMOTE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

	// One request as taken from the input stream.
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [VALUE_W-1:0]  push_value;
		logic [START_W-1:0]  start_index;
		logic [RUN_W-1:0]    run_length;
	} req_t;

	// One result as handed to the output stream.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  pop_value;
		logic [FILL_W-1:0]   fill_level;
	} res_t;

endpackage

/* rtl/swbp_ram.sv */
// Simple dual-port synchronous memory with a registered read port.
module swbp_ram
	import swbp_pkg::*;
#(
	parameter int DEPTH = STACK_DEPTH_DEF,
	parameter int WIDTH = WORD_BITS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/swbp_seq.sv */
// Request sequencer: push, pop and the three-pass block promotion over the memories.
module swbp_seq
	import swbp_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);
	// Width that holds start plus run length and the fill level without overflow.
	localparam int CW = ((LW > RUN_W + 1) ? LW : RUN_W + 1) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COPY,
		S_SHIFT,
		S_BACK,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [LW-1:0]       level_q;
	logic [STATUS_W-1:0] status_q;
	logic                pop_q;
	logic [CW-1:0]       idx_q;

	// Promotion operands, held for the walk.
	logic [CW-1:0] start_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] above_q;

	// Write stage that follows each read of the walk in the next cycle.
	logic          wr_s1;
	logic          wr_scr_s1;
	logic          src_scr_s1;
	logic [AW-1:0] wr_addr_s1;

	logic                 accept;
	logic                 full;
	logic                 empty;
	logic [CW-1:0]        req_start;
	logic [CW-1:0]        req_len;
	logic [CW-1:0]        req_end;
	logic [CW-1:0]        level_ext;
	logic                 walk_last;
	logic [CW-1:0]        copy_addr;
	logic [CW-1:0]        shift_rd_addr;
	logic [CW-1:0]        back_wr_addr;
	logic [LW-1:0]        pop_addr;

	logic                 ent_we;
	logic [AW-1:0]        ent_wa;
	logic [WORD_BITS-1:0] ent_wd;
	logic                 ent_re;
	logic [AW-1:0]        ent_ra;
	logic [WORD_BITS-1:0] ent_rd;
	logic                 scr_we;
	logic                 scr_re;
	logic [WORD_BITS-1:0] scr_rd;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign full      = (level_q >= LW'(STACK_DEPTH));
	assign empty     = (level_q == '0);
	assign req_start = CW'(req.start_index);
	assign req_len   = CW'(req.run_length);
	assign req_end   = req_start + req_len;
	assign level_ext = CW'(level_q);
	assign pop_addr  = level_q - LW'(1);

	// Addresses of the walk.
	assign copy_addr     = start_q + idx_q;
	assign shift_rd_addr = start_q + len_q + idx_q;
	assign back_wr_addr  = level_ext - len_q + idx_q;

	// Last step of the current pass.
	always_comb begin
		case (state_q)
			S_SHIFT: walk_last = (idx_q == above_q - CW'(1));
			default: walk_last = (idx_q == len_q - CW'(1));
		endcase
	end

	// Entry memory ports: push writes directly, the walk writes in the cycle after reading.
	always_comb begin
		ent_we = (accept && req.opcode == OP_PUSH && !full) || (wr_s1 && !wr_scr_s1);
		ent_wa = wr_s1 ? wr_addr_s1 : level_q[AW-1:0];
		if (wr_s1) begin
			ent_wd = src_scr_s1 ? scr_rd : ent_rd;
		end else begin
			ent_wd = WORD_BITS'(req.push_value);
		end
		ent_re = (accept && req.opcode == OP_POP && !empty)
			|| state_q == S_COPY || state_q == S_SHIFT;
		case (state_q)
			S_COPY:  ent_ra = copy_addr[AW-1:0];
			S_SHIFT: ent_ra = shift_rd_addr[AW-1:0];
			default: ent_ra = pop_addr[AW-1:0];
		endcase
		scr_we = wr_s1 && wr_scr_s1;
		scr_re = (state_q == S_BACK);
	end

	swbp_ram #(
		.DEPTH(STACK_DEPTH),
		.WIDTH(WORD_BITS)
	) u_entry (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_wa),
		.wdata(ent_wd),
		.re   (ent_re),
		.raddr(ent_ra),
		.rdata(ent_rd)
	);

	swbp_ram #(
		.DEPTH(STACK_DEPTH),
		.WIDTH(WORD_BITS)
	) u_scratch (
		.clk  (clk),
		.we   (scr_we),
		.waddr(wr_addr_s1),
		.wdata(ent_rd),
		.re   (scr_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(scr_rd)
	);

	// Control state machine with the fill level and the pending result code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			level_q    <= '0;
			status_q   <= STAT_OK;
			pop_q      <= 1'b0;
			idx_q      <= '0;
			wr_s1      <= 1'b0;
			wr_scr_s1  <= 1'b0;
			src_scr_s1 <= 1'b0;
		end else begin
			wr_s1      <= (state_q == S_COPY || state_q == S_SHIFT || state_q == S_BACK);
			wr_scr_s1  <= (state_q == S_COPY);
			src_scr_s1 <= (state_q == S_BACK);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= STAT_OK;
						pop_q    <= 1'b0;
						idx_q    <= '0;
						state_q  <= S_DONE;
						case (req.opcode)
							OP_PUSH: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									level_q <= level_q + LW'(1);
								end
							end
							OP_POP: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									level_q <= pop_addr;
									pop_q   <= 1'b1;
								end
							end
							OP_PROMOTE: begin
								// A run that already sits on top needs no move.
								if (req_len == '0) begin
									status_q <= STAT_OK;
								end else if (req_end > level_ext) begin
									status_q <= STAT_RANGE;
								end else if (req_end != level_ext) begin
									state_q <= S_COPY;
								end
							end
							default: status_q <= STAT_OK;
						endcase
					end
				end
				S_COPY: begin
					idx_q <= walk_last ? '0 : idx_q + CW'(1);
					if (walk_last) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					idx_q <= walk_last ? '0 : idx_q + CW'(1);
					if (walk_last) begin
						state_q <= S_BACK;
					end
				end
				S_BACK: begin
					idx_q <= walk_last ? '0 : idx_q + CW'(1);
					if (walk_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Promotion operands and write-stage address.
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= req_start;
			len_q   <= req_len;
			above_q <= level_ext - req_end;
		end
		case (state_q)
			S_COPY:  wr_addr_s1 <= idx_q[AW-1:0];
			S_SHIFT: wr_addr_s1 <= copy_addr[AW-1:0];
			default: wr_addr_s1 <= back_wr_addr[AW-1:0];
		endcase
	end

	// Result of the finished request.
	assign res_valid     = (state_q == S_DONE);
	assign res.status    = status_q;
	assign res.pop_value = pop_q ? VALUE_W'(ent_rd) : '0;
	assign res.fill_level = FILL_W'(level_q);

endmodule

/* rtl/stack_with_block_promote_core.sv */
// Top level of the LIFO stack with block promotion: stream ports and result register.
//
// A fixed-depth stack of STACK_DEPTH words held in a synchronous entry memory, with
// a scratch memory of the same size for block promotion. One request is worked at
// a time and every request gives one result. Push, pop, a promotion of zero length,
// an out-of-range promotion, a promotion of a run that is already on top, and the
// unused opcode go straight from the request to the result. A promotion that moves
// entries walks the single read and write port of the entry memory once to save the
// run, once to shift the entries above it down, and once to write the run back on top.
// The next request is taken while a result still waits in the output register.
module stack_with_block_promote_core
	import swbp_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int WORD_BITS   = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // push_value[31:0], start_index[37:32], run_length[44:38]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // pop_value[31:0], fill_level[38:32]
	output logic [1:0]  m_tuser    // status[1:0]
);

	req_t req;
	res_t res;
	res_t out_q;
	logic out_valid_q;
	logic res_valid;
	logic res_take;
	logic out_free;

	// Unpack the incoming request.
	assign req.opcode      = s_tuser;
	assign req.push_value  = s_tdata[31:0];
	assign req.start_index = s_tdata[37:32];
	assign req.run_length  = s_tdata[44:38];

	swbp_seq #(
		.STACK_DEPTH(STACK_DEPTH),
		.WORD_BITS  (WORD_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(out_free),
		.res      (res)
	);

	assign out_free = !out_valid_q || m_tready;
	assign res_take = res_valid && out_free;

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.fill_level, out_q.pop_value};
	assign m_tuser  = out_q.status;

endmodule
